### rtl/core/ldpg_pkg.sv
package ldpg_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned BASE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 17'd256;
  localparam logic [BASE_W-1:0]     BASE_RESET  = 8'd3;

  typedef enum logic {
    MODE_HAMMERSLEY = 1'b0,
    MODE_HALTON     = 1'b1
  } mode_e;

  // radix 0 and 1 behave as radix 2
  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = (b < BASE_W'(2)) ? BASE_W'(2) : b;
    return r;
  endfunction

endpackage

### rtl/core/ldpg_recip.sv
module ldpg_recip import ldpg_pkg::*; #(
  parameter int unsigned IB = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BASE_W-1:0] base_i,
  output logic              busy_o,
  output logic [IB-1:0]     recip_o
);

  // floor(2^IB / b), one quotient bit per cycle
  localparam int unsigned CW = $clog2(IB + 2);
  localparam int unsigned R0 = (1 << IB) / 3;

  logic [CW-1:0]     cnt_q;
  logic [BASE_W-1:0] rem_q, div_q;
  logic [IB-1:0]     quo_q;
  logic [CW-1:0]     bitpos;
  logic [BASE_W:0]   rs;
  logic              ge;

  assign bitpos = cnt_q - CW'(1);
  assign rs     = {rem_q, (bitpos == CW'(IB))};
  assign ge     = rs >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      quo_q <= IB'(R0);
    end else if (start_i) begin
      cnt_q <= CW'(IB + 1);
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
      quo_q <= {quo_q[IB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= base_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? BASE_W'(rs - {1'b0, div_q}) : BASE_W'(rs);
    end
  end

  assign busy_o  = cnt_q != '0;
  assign recip_o = quo_q;

endmodule

### rtl/core/ldpg_div_pipe.sv
module ldpg_div_pipe #(
  parameter int unsigned DW = 24,
  parameter int unsigned FB = 24,
  parameter int unsigned SW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [FB-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // restoring division, one quotient bit per stage; needs rem_i < den_i
  logic          v_q    [0:FB];
  logic [DW-1:0] rem_q  [0:FB];
  logic [DW-1:0] den_q  [0:FB];
  logic [FB-1:0] quo_q  [0:FB];
  logic [SW-1:0] side_q [0:FB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < FB; i++) begin : g_stage
    logic [DW:0] rs;
    logic        ge;

    assign rs = {rem_q[i], 1'b0};
    assign ge = rs >= {1'b0, den_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= ge ? DW'(rs - {1'b0, den_q[i]}) : DW'(rs);
        den_q[i+1]  <= den_q[i];
        quo_q[i+1]  <= FB'({quo_q[i], ge});
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[FB];
  assign quo_o   = quo_q[FB];
  assign side_o  = side_q[FB];

endmodule

### rtl/core/low_discrepancy_2d_point_generator_top.sv
// Hammersley / Halton 2D point generator. Takes one point index per clock while
// in_stall_o is low and returns (u, v) in Q0.24. u is the bit reversal of the
// index; v is (2k+1)/(2n) or the radical inverse of k in second_base, per
// sequence_mode. The Halton digits come from INDEX_BITS two-stage digit slices
// (reciprocal multiply, then remainder correction) and both v forms share one
// FRAC_BITS-stage restoring divider. After a write to second_base the input
// stalls while the reciprocal of the base is rebuilt, one bit per cycle. An
// output stall while out_valid_o is high freezes the whole pipeline.
module low_discrepancy_2d_point_generator_top import ldpg_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_W-1:0]    point_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_W-1:0]    coord_u_o,
  output logic [COORD_W-1:0]    coord_v_o
);

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned PW = 2 * IB;
  localparam int unsigned XW = IB + BASE_W;
  localparam int unsigned DW = (XW > 18) ? XW : 18;
  localparam int unsigned SW = FB + 1;

  mode_e                 mode_q;
  logic [CFG_DATA_W-1:0] count_q;
  logic [BASE_W-1:0]     base_q;
  logic [BASE_W-1:0]     b_eff;
  logic [IB-1:0]         recip;
  logic                  busy;
  logic                  en;
  logic                  accept;
  logic [IB-1:0]         k_in;
  logic [FB-1:0]         u_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HAMMERSLEY;
      count_q <= COUNT_RESET;
      base_q  <= BASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:  mode_q  <= mode_e'(cfg_wdata_i[0]);
        CFG_COUNT: count_q <= cfg_wdata_i;
        CFG_BASE:  base_q  <= cfg_wdata_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign b_eff = eff_base(base_q);

  ldpg_recip #(.IB(IB)) u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i && (cfg_idx_i == CFG_BASE)),
    .base_i  (eff_base(cfg_wdata_i[BASE_W-1:0])),
    .busy_o  (busy),
    .recip_o (recip)
  );

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en || busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign k_in       = IB'(point_index_i);

  for (genvar i = 0; i < FB; i++) begin : g_rev
    if (i < IB) begin : g_bit
      assign u_in[FB-1-i] = k_in[i];
    end else begin : g_zero
      assign u_in[FB-1-i] = 1'b0;
    end
  end

  // digit slices: d* enter slice j, a* hold the reciprocal product
  logic          dv_q   [0:IB];
  logic [IB-1:0] dk_q   [0:IB];
  logic [IB-1:0] dk0_q  [0:IB];
  logic [DW-1:0] dmir_q [0:IB];
  logic [DW-1:0] dden_q [0:IB];
  mode_e         dmode_q[0:IB];
  logic [FB-1:0] du_q   [0:IB];

  logic          av_q   [0:IB-1];
  logic [IB-1:0] ak_q   [0:IB-1];
  logic [IB-1:0] ak0_q  [0:IB-1];
  logic [IB-1:0] aq_q   [0:IB-1];
  logic [DW-1:0] amir_q [0:IB-1];
  logic [DW-1:0] aden_q [0:IB-1];
  mode_e         amode_q[0:IB-1];
  logic [FB-1:0] au_q   [0:IB-1];
  logic [XW-1:0] ar0    [0:IB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dk_q[0]    <= k_in;
      dk0_q[0]   <= k_in;
      dmir_q[0]  <= '0;
      dden_q[0]  <= DW'(1);
      dmode_q[0] <= mode_q;
      du_q[0]    <= u_in;
    end
  end

  for (genvar j = 0; j < IB; j++) begin : g_dig
    logic [PW-1:0]     prod;
    logic [XW-1:0]     qb;
    logic              corr;
    logic [BASE_W-1:0] r;
    logic              act;

    // q0 is floor(k/b) or one less
    assign prod = PW'(dk_q[j]) * PW'(recip);
    assign qb   = XW'(aq_q[j]) * XW'(b_eff);
    assign ar0[j] = XW'(ak_q[j]) - qb;
    assign corr = ar0[j] >= XW'(b_eff);
    assign r    = corr ? BASE_W'(ar0[j] - XW'(b_eff)) : BASE_W'(ar0[j]);
    assign act  = ak_q[j] != '0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        av_q[j]   <= 1'b0;
        dv_q[j+1] <= 1'b0;
      end else if (en) begin
        av_q[j]   <= dv_q[j];
        dv_q[j+1] <= av_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ak_q[j]    <= dk_q[j];
        ak0_q[j]   <= dk0_q[j];
        aq_q[j]    <= prod[PW-1:IB];
        amir_q[j]  <= dmir_q[j];
        aden_q[j]  <= dden_q[j];
        amode_q[j] <= dmode_q[j];
        au_q[j]    <= du_q[j];

        dk0_q[j+1]   <= ak0_q[j];
        dmode_q[j+1] <= amode_q[j];
        du_q[j+1]    <= au_q[j];
        if (act) begin
          dk_q[j+1]   <= aq_q[j] + IB'(corr);
          dmir_q[j+1] <= DW'(amir_q[j] * DW'(b_eff)) + DW'(r);
          dden_q[j+1] <= DW'(aden_q[j] * DW'(b_eff));
        end else begin
          dk_q[j+1]   <= ak_q[j];
          dmir_q[j+1] <= amir_q[j];
          dden_q[j+1] <= aden_q[j];
        end
      end
    end
  end

  logic          halton;
  logic          sat;
  logic [DW-1:0] rem0;
  logic [DW-1:0] den0;
  logic [FB-1:0] quo;
  logic [SW-1:0] side;
  logic [FB-1:0] v_full;

  assign halton = dmode_q[IB] == MODE_HALTON;
  assign sat    = !halton && (25'(dk0_q[IB]) >= 25'(count_q));
  assign rem0   = halton ? dmir_q[IB] : DW'({dk0_q[IB], 1'b1});
  assign den0   = halton ? dden_q[IB] : DW'({count_q, 1'b0});

  ldpg_div_pipe #(.DW(DW), .FB(FB), .SW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_q[IB]),
    .rem_i   (rem0),
    .den_i   (den0),
    .side_i  ({sat, du_q[IB]}),
    .valid_o (out_valid_o),
    .quo_o   (quo),
    .side_o  (side)
  );

  assign v_full    = side[FB] ? '1 : quo;
  assign coord_u_o = COORD_W'(side[FB-1:0]);
  assign coord_v_o = COORD_W'(v_full);

`ifndef SYNTHESIS
  a_recip_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ((XW+1)'(recip) * (XW+1)'(b_eff) <= ((XW+1)'(1) << IB)) &&
              (((XW+1)'(recip) + (XW+1)'(1)) * (XW+1)'(b_eff) > ((XW+1)'(1) << IB)))
    else $error("reciprocal of base out of range");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[IB] && !sat |-> rem0 < den0)
    else $error("divider input not a proper fraction");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_we_i && (cfg_idx_i == CFG_BASE)) |-> in_stall_o)
    else $error("transfer taken while base reciprocal rebuilds");

  for (genvar j = 0; j < IB; j++) begin : g_chk
    a_digit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
      av_q[j] |-> ar0[j] < (XW'(b_eff) << 1))
      else $error("digit remainder needs more than one correction");
  end
`endif

endmodule
